// ===== design/rdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and constants of the ring deque: operation codes, sequencer
// states and the fixed field widths of the command and result ports.
// ----------------------------------------------------------------------------
package rdq_pkg;

	localparam int FUNC_W  = 3;
	localparam int POS_W   = 4;
	localparam int WORD_W  = 32;
	localparam int SLOTS_W = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [SLOTS_W-1:0] SLOTS_RESET   = 5'd16;
	localparam logic               REG_SLOTS_IDX = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FN_ENQ    = 3'd0,
		FN_PUSH   = 3'd1,
		FN_DEQ    = 3'd2,
		FN_PEEK   = 3'd3,
		FN_DROP   = 3'd4,
		FN_REMOVE = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ADJ,
		ST_RD_WAIT,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== design/rdq_wrap_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_wrap_unit
// Shared ring slot adder: base plus offset, wrapped once at the ring size.
// Offsets of size-1 give the decrement.
// ----------------------------------------------------------------------------
module rdq_wrap_unit #(
	parameter int AW = 5
) (
	input  wire logic [AW-1:0] base,
	input  wire logic [AW-1:0] off,
	input  wire logic [AW-1:0] size,
	output logic      [AW-1:0] result
);

	logic [AW:0] sum;

	always_comb begin
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= {1'b0, size}) begin
			sum = sum - {1'b0, size};
		end
		result = sum[AW-1:0];
	end

endmodule
`default_nettype wire

// ===== design/rdq_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdq_mem
// Entry store of the ring: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module rdq_mem #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int PW         = 4
) (
	input  wire logic                  clk,
	input  wire logic                  we,
	input  wire logic [PW-1:0]         waddr,
	input  wire logic [DATA_WIDTH-1:0] wdata,
	input  wire logic [PW-1:0]         raddr,
	output logic      [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== design/ring_deque_with_remove.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_deque_with_remove
// Ring-buffer deque of data words with enqueue, push, dequeue, peek, drop and
// remove at a position, run by a small sequencer around one wrap adder.
//
// channel   signals                                         transaction
// command   start, busy, func, force_req, data_in,          start & !busy
//           position_or_count
// result    done, ok, data_out, count                       done (one cycle)
// config    psel, penable, pwrite, paddr, pwdata, prdata,   psel & penable
//           pready                                          & pwrite
//
// busy is high from the accept edge until the result cycle ends; the next
// command is taken from the idle state that follows. Enqueue, push, drop and
// failed ops run execute then result; a forced enqueue on a full ring adds a
// head adjust, dequeue and peek a read wait. remove moves each entry behind
// the removed one by a read then a write through the single store port pair.
// no clearing pass after reset; the result side cannot stall.
// ----------------------------------------------------------------------------
module ring_deque_with_remove
	import rdq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic               force_req,
	input  wire logic [WORD_W-1:0]  data_in,
	input  wire logic [POS_W-1:0]   position_or_count,
	output logic                    done,
	output logic                    ok,
	output logic      [WORD_W-1:0]  data_out,
	output logic      [POS_W-1:0]   count,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AW = (PW + 1 > SLOTS_W) ? PW + 1 : SLOTS_W;

	state_t                state_q, state_d;
	logic [FUNC_W-1:0]     func_q;
	logic                  force_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [POS_W-1:0]      pos_q;
	logic [SLOTS_W-1:0]    slots_q;
	logic [PW-1:0]         head_q, head_d;
	logic [PW-1:0]         tail_q, tail_d;
	logic [PW-1:0]         p_q, p_d;
	logic [PW-1:0]         q_q, q_d;
	logic [AW-1:0]         left_q, left_d;
	logic                  ok_q, ok_d;
	logic [DATA_WIDTH-1:0] data_q, data_d;

	logic [AW-1:0] size, cnt, head_e, tail_e, pos_e, drop_n, rem_left;
	logic [AW-1:0] alu_base, alu_off, alu_res;
	logic [PW-1:0] alu_res_p;
	logic          full, enq_go, pos_ok, cfg_we, accept;

	logic                  mem_we;
	logic [PW-1:0]         mem_wa, mem_ra;
	logic [DATA_WIDTH-1:0] mem_wd, mem_rd;

	assign accept = start && (state_q == ST_IDLE);
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SLOTS_IDX);

	always_comb begin
		if (slots_q < SLOTS_W'(2)) begin
			size = AW'(2);
		end else if (AW'(slots_q) > AW'(DEPTH)) begin
			size = AW'(DEPTH);
		end else begin
			size = AW'(slots_q);
		end
	end

	assign head_e    = AW'(head_q);
	assign tail_e    = AW'(tail_q);
	assign pos_e     = AW'(pos_q);
	assign cnt       = (tail_e >= head_e) ? (tail_e - head_e) : (tail_e + size - head_e);
	assign drop_n    = (pos_e > cnt) ? cnt : pos_e;
	assign full      = (cnt + AW'(1)) >= size;
	assign enq_go    = !full || force_q;
	assign pos_ok    = pos_e < cnt;
	assign rem_left  = cnt - pos_e - AW'(1);
	assign alu_res_p = alu_res[PW-1:0];

	rdq_wrap_unit #(
		.AW(AW)
	) u_wrap (
		.base   (alu_base),
		.off    (alu_off),
		.size   (size),
		.result (alu_res)
	);

	rdq_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.PW         (PW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.raddr (mem_ra),
		.rdata (mem_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (func_q)
					FN_ENQ: begin
						state_d = (enq_go && full) ? ST_ADJ : ST_DONE;
					end
					FN_DEQ: begin
						state_d = (cnt != '0) ? ST_RD_WAIT : ST_DONE;
					end
					FN_PEEK: begin
						state_d = pos_ok ? ST_RD_WAIT : ST_DONE;
					end
					FN_REMOVE: begin
						if (!pos_ok) begin
							state_d = ST_DONE;
						end else if (rem_left != '0) begin
							state_d = ST_SHIFT_RD;
						end else begin
							state_d = ST_ADJ;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_ADJ:      state_d = ST_DONE;
			ST_RD_WAIT:  state_d = ST_DONE;
			ST_SHIFT_RD: state_d = ST_SHIFT_WR;
			ST_SHIFT_WR: state_d = (left_q == AW'(1)) ? ST_ADJ : ST_SHIFT_RD;
			ST_DONE:     state_d = ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		alu_base = head_e;
		alu_off  = '0;
		mem_we   = 1'b0;
		mem_wa   = tail_q;
		mem_wd   = word_q;
		mem_ra   = head_q;
		head_d   = head_q;
		tail_d   = tail_q;
		p_d      = p_q;
		q_d      = q_q;
		left_d   = left_q;
		ok_d     = ok_q;
		data_d   = data_q;
		unique case (state_q)
			ST_IDLE: begin
				ok_d   = 1'b0;
				data_d = '0;
			end
			ST_EXEC: begin
				case (func_q)
					FN_ENQ: begin
						alu_base = tail_e;
						alu_off  = AW'(1);
						if (enq_go) begin
							mem_we = 1'b1;
							mem_wa = tail_q;
							tail_d = alu_res_p;
							ok_d   = 1'b1;
						end
					end
					FN_PUSH: begin
						alu_off = size - AW'(1);
						if (alu_res_p != tail_q) begin
							mem_we = 1'b1;
							mem_wa = alu_res_p;
							head_d = alu_res_p;
							ok_d   = 1'b1;
						end
					end
					FN_DEQ: begin
						alu_off = AW'(1);
						if (cnt != '0) begin
							head_d = alu_res_p;
							ok_d   = 1'b1;
						end
					end
					FN_PEEK: begin
						alu_off = pos_e;
						mem_ra  = alu_res_p;
						ok_d    = pos_ok;
					end
					FN_DROP: begin
						alu_off = drop_n;
						head_d  = alu_res_p;
						ok_d    = 1'b1;
					end
					FN_REMOVE: begin
						alu_off = pos_e;
						p_d     = alu_res_p;
						left_d  = rem_left;
						ok_d    = pos_ok;
					end
					default: begin
						ok_d = 1'b0;
					end
				endcase
			end
			ST_ADJ: begin
				if (func_q == FN_ENQ) begin
					alu_off = AW'(1);
					head_d  = alu_res_p;
				end else begin
					alu_base = tail_e;
					alu_off  = size - AW'(1);
					tail_d   = alu_res_p;
				end
			end
			ST_RD_WAIT: begin
				data_d = mem_rd;
			end
			ST_SHIFT_RD: begin
				alu_base = AW'(p_q);
				alu_off  = AW'(1);
				mem_ra   = alu_res_p;
				q_d      = alu_res_p;
			end
			ST_SHIFT_WR: begin
				mem_we = 1'b1;
				mem_wa = p_q;
				mem_wd = mem_rd;
				p_d    = q_q;
				left_d = left_q - AW'(1);
			end
			ST_DONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			slots_q <= SLOTS_RESET;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			if (cfg_we) begin
				slots_q <= pwdata[SLOTS_W-1:0];
				head_q  <= '0;
				tail_q  <= '0;
			end else begin
				head_q <= head_d;
				tail_q <= tail_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			force_q <= force_req;
			word_q  <= DATA_WIDTH'(data_in);
			pos_q   <= position_or_count;
		end
		p_q    <= p_d;
		q_q    <= q_d;
		left_q <= left_d;
		data_q <= data_d;
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_DONE);
	assign ok       = ok_q;
	assign data_out = WORD_W'(data_q);
	assign count    = cnt[POS_W-1:0];
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_SLOTS_IDX) ? PDATA_W'(slots_q) : '0;

endmodule
`default_nettype wire

// ===== tb/ring_deque_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_deque_checker
// Watches the command, result and register ports of the ring deque. It keeps
// its own copy of the ring, the pointers and the slot count, predicts the
// outcome of every accepted command and compares each result transaction
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ring_deque_checker
	import rdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic               force_req,
	input  wire logic [WORD_W-1:0]  data_in,
	input  wire logic [POS_W-1:0]   position_or_count,
	input  wire logic               done,
	input  wire logic               ok,
	input  wire logic [WORD_W-1:0]  data_out,
	input  wire logic [POS_W-1:0]   count,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic               pready,
	input  wire logic               end_check,
	output int                      mismatches
);

	localparam int PTR_W       = $clog2(DEPTH);
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] word;
		logic [POS_W-1:0]  held;
	} deque_result_t;

	logic [WORD_W-1:0]  entry_mirror [DEPTH];
	logic [PTR_W-1:0]   head_ptr;
	logic [PTR_W-1:0]   tail_ptr;
	logic [SLOTS_W-1:0] slots_reg;
	deque_result_t      awaited_results [$];
	int unsigned        results_checked;
	bit                 leftover_checked;

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: result %0d: %s", $time, results_checked, msg);
		mismatches++;
	endtask

	function automatic int unsigned ring_len();
		int unsigned s;
		s = 32'(slots_reg);
		if (s < 2) s = 2;
		if (s > DEPTH) s = DEPTH;
		return s;
	endfunction

	function automatic int unsigned next_slot(input int unsigned p, input int unsigned sz);
		return (p + 1 >= sz) ? 0 : p + 1;
	endfunction

	function automatic int unsigned held_entries(input int unsigned sz);
		int unsigned h, t;
		h = 32'(head_ptr);
		t = 32'(tail_ptr);
		if (t >= h) return t - h;
		return t + sz - h;
	endfunction

	// applies one command to the mirrored deque and returns its outcome
	function automatic deque_result_t predict_deque_op(input logic [FUNC_W-1:0] op,
			input logic frc, input logic [WORD_W-1:0] word, input logic [POS_W-1:0] pos_in);
		int unsigned   sz, cnt, pos, p, q;
		deque_result_t r;
		sz  = ring_len();
		cnt = held_entries(sz);
		pos = 32'(pos_in);
		r   = '0;
		case (op)
			FN_ENQ: begin
				if (cnt + 1 < sz || frc) begin
					// full with force: oldest entry goes first
					if (cnt + 1 >= sz && cnt != 0) head_ptr = PTR_W'(next_slot(head_ptr, sz));
					p = next_slot(tail_ptr, sz);
					if (p != head_ptr) begin
						entry_mirror[tail_ptr] = word;
						tail_ptr = PTR_W'(p);
						r.ok = 1'b1;
					end
				end
			end
			FN_PUSH: begin
				p = (head_ptr == 0) ? sz - 1 : head_ptr - 1;
				if (p != tail_ptr) begin
					entry_mirror[PTR_W'(p)] = word;
					head_ptr = PTR_W'(p);
					r.ok = 1'b1;
				end
			end
			FN_DEQ: begin
				if (cnt != 0) begin
					r.word = entry_mirror[head_ptr];
					head_ptr = PTR_W'(next_slot(head_ptr, sz));
					r.ok = 1'b1;
				end
			end
			FN_PEEK: begin
				if (pos < cnt) begin
					p = head_ptr + pos;
					if (p >= sz) p -= sz;
					r.word = entry_mirror[PTR_W'(p)];
					r.ok = 1'b1;
				end
			end
			FN_DROP: begin
				if (pos > cnt) pos = cnt;
				repeat (pos) head_ptr = PTR_W'(next_slot(head_ptr, sz));
				r.ok = 1'b1;
			end
			FN_REMOVE: begin
				if (pos < cnt) begin
					p = head_ptr + pos;
					if (p >= sz) p -= sz;
					for (int unsigned i = pos + 1; i < cnt; i++) begin
						q = next_slot(p, sz);
						entry_mirror[PTR_W'(p)] = entry_mirror[PTR_W'(q)];
						p = q;
					end
					tail_ptr = (tail_ptr == 0) ? PTR_W'(sz - 1) : tail_ptr - 1'b1;
					r.ok = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.held = POS_W'(held_entries(sz));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t exp_r;
		if (!arst_n) begin
			head_ptr         = '0;
			tail_ptr         = '0;
			slots_reg        = SLOTS_RESET;
			mismatches       = 0;
			results_checked  = 0;
			leftover_checked = 1'b0;
			awaited_results.delete();
		end else begin
			if (done) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result transaction with no command outstanding");
				end else begin
					exp_r = awaited_results.pop_front();
					if (ok !== exp_r.ok)
						report_mismatch($sformatf("ok got %b expected %b", ok, exp_r.ok));
					if (data_out !== exp_r.word)
						report_mismatch($sformatf("data_out got %h expected %h",
							data_out, exp_r.word));
					if (count !== exp_r.held)
						report_mismatch($sformatf("count got %0d expected %0d",
							count, exp_r.held));
				end
				results_checked++;
			end
			if (start && !busy)
				awaited_results.push_back(predict_deque_op(func, force_req, data_in,
					position_or_count));
			// register write empties the deque
			if (psel && penable && pwrite && pready
					&& paddr[PADDR_W-1:2] == REG_SLOTS_IDX) begin
				slots_reg = pwdata[SLOTS_W-1:0];
				head_ptr  = '0;
				tail_ptr  = '0;
			end
			if (end_check && !leftover_checked) begin
				if (awaited_results.size() != 0)
					report_mismatch($sformatf("%0d results never arrived",
						awaited_results.size()));
				leftover_checked = 1'b1;
			end
		end
	end

endmodule

// ===== tb/tb_ring_deque_with_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_deque_with_remove
// Drives the ring deque with a directed set of commands covering empty, full,
// forced enqueue, saturating drop, bad positions and unused codes, then with
// random commands over several ring sizes, including out-of-range ones. Fill
// and drain biases alternate so the deque sweeps between empty and full, and
// command gaps are random with bursts of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_ring_deque_with_remove;
	import rdq_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASE_ITEMS    = 170;
	localparam int RANDOM_PHASES  = 10;
	localparam int MAX_GAP        = 13;

	localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [FUNC_W-1:0]  func;
	logic               force_req;
	logic [WORD_W-1:0]  data_in;
	logic [POS_W-1:0]   position_or_count;
	logic               done;
	logic               ok;
	logic [WORD_W-1:0]  data_out;
	logic [POS_W-1:0]   count;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               end_check;
	int                 mismatches;

	int unsigned cmds_issued  = 0;
	int unsigned results_seen = 0;
	int unsigned stall_cycles = 0;
	bit          burst_mode   = 1'b0;
	bit          filling      = 1'b1;

	logic [SLOTS_W-1:0] phase_slots [8] = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd7, 5'd1, 5'd17, 5'd4};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	ring_deque_with_remove #(
		.DEPTH(16),
		.DATA_WIDTH(32)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.force_req(force_req),
		.data_in(data_in),
		.position_or_count(position_or_count),
		.done(done),
		.ok(ok),
		.data_out(data_out),
		.count(count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	ring_deque_checker #(
		.DEPTH(16)
	) deque_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.force_req(force_req),
		.data_in(data_in),
		.position_or_count(position_or_count),
		.done(done),
		.ok(ok),
		.data_out(data_out),
		.count(count),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.end_check(end_check),
		.mismatches(mismatches)
	);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (done) results_seen <= results_seen + 1;
		if ((start && !busy) || done || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_command(input logic [FUNC_W-1:0] op, input logic frc,
			input logic [WORD_W-1:0] word, input logic [POS_W-1:0] pos);
		int unsigned gap;
		gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start             <= 1'b1;
		func              <= op;
		force_req         <= frc;
		data_in           <= word;
		position_or_count <= pos;
		@(posedge clk);
		while (busy) @(posedge clk);
		cmds_issued++;
	endtask

	task automatic wait_for_idle();
		start <= 1'b0;
		@(posedge clk);
		while (results_seen != cmds_issued || busy) @(posedge clk);
	endtask

	task automatic write_slots(input logic [SLOTS_W-1:0] slots);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_SLOTS_IDX, 2'b00};
		pwdata  <= ($urandom() & ~PDATA_W'(5'h1F)) | PDATA_W'(slots);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		logic [FUNC_W-1:0] op;
		logic [POS_W-1:0]  pos;
		int unsigned       roll;

		arst_n            <= 1'b0;
		start             <= 1'b0;
		func              <= FN_ENQ;
		force_req         <= 1'b0;
		data_in           <= '0;
		position_or_count <= '0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		end_check         <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque, unused codes, then a few entries at the reset ring size
		send_command(FN_DEQ, 1'b0, $urandom(), 4'd0);
		send_command(FN_PEEK, 1'b0, $urandom(), 4'd0);
		send_command(FN_REMOVE, 1'b0, $urandom(), 4'd0);
		send_command(FN_DROP, 1'b0, $urandom(), 4'hF);
		send_command(FN_SPARE_A, 1'b1, 32'hFFFF_FFFF, 4'hF);
		send_command(FN_SPARE_B, 1'b0, 32'h0, 4'd0);
		send_command(FN_ENQ, 1'b0, 32'h0, 4'd0);
		send_command(FN_ENQ, 1'b1, 32'hFFFF_FFFF, 4'hF);
		send_command(FN_PUSH, 1'b1, 32'hA5A5_A5A5, 4'hF);
		send_command(FN_PEEK, 1'b0, 32'h0, 4'd2);
		send_command(FN_PEEK, 1'b0, 32'h0, 4'd3);
		send_command(FN_PEEK, 1'b0, 32'h0, 4'hF);
		send_command(FN_REMOVE, 1'b0, 32'h0, 4'd1);
		send_command(FN_DEQ, 1'b0, 32'h0, 4'd0);

		// tiny ring: full cases
		wait_for_idle();
		write_slots(5'd3);
		send_command(FN_ENQ, 1'b0, 32'h1234_5678, 4'd0);
		send_command(FN_ENQ, 1'b0, 32'h5A5A_5A5A, 4'd0);
		send_command(FN_ENQ, 1'b0, 32'hDEAD_BEEF, 4'd0);
		send_command(FN_ENQ, 1'b1, 32'hC0FF_EE00, 4'd0);
		send_command(FN_PUSH, 1'b0, 32'h8000_0001, 4'd0);
		send_command(FN_REMOVE, 1'b0, 32'h0, 4'd1);
		send_command(FN_REMOVE, 1'b0, 32'h0, 4'd0);
		send_command(FN_DROP, 1'b0, 32'h0, 4'd9);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_for_idle();
			write_slots(ph < 8 ? phase_slots[3'(ph)] : SLOTS_W'($urandom_range(0, 31)));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 39) == 0) filling = !filling;
				if ($urandom_range(0, 24) == 0) burst_mode = !burst_mode;
				roll = $urandom_range(0, 99);
				if (filling) begin
					if (roll < 38)      op = FN_ENQ;
					else if (roll < 56) op = FN_PUSH;
					else if (roll < 66) op = FN_DEQ;
					else if (roll < 78) op = FN_PEEK;
					else if (roll < 82) op = FN_DROP;
					else if (roll < 96) op = FN_REMOVE;
					else if (roll < 98) op = FN_SPARE_A;
					else                op = FN_SPARE_B;
				end else begin
					if (roll < 14)      op = FN_ENQ;
					else if (roll < 20) op = FN_PUSH;
					else if (roll < 48) op = FN_DEQ;
					else if (roll < 62) op = FN_PEEK;
					else if (roll < 70) op = FN_DROP;
					else if (roll < 96) op = FN_REMOVE;
					else if (roll < 98) op = FN_SPARE_A;
					else                op = FN_SPARE_B;
				end
				if (op == FN_DROP)
					pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 15))
						: POS_W'($urandom_range(0, 2));
				else
					pos = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 3))
						: POS_W'($urandom_range(0, 15));
				send_command(op, 1'($urandom_range(0, 1)), $urandom(), pos);
			end
		end

		wait_for_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
